FILE: sv/ncs_pkg.sv
// Shared constants, types and codes for the nearest palette colour search block.
package ncs_pkg;

	// Palette geometry
	localparam int PALETTE_ENTRIES = 256;
	localparam int PAL_AW          = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;

	// Field and datapath widths
	localparam int CHAN_W  = 8;
	localparam int IDX_W   = 8;
	localparam int QUERY_W = 11;
	localparam int DIFF_W  = 12;   // query minus entry, -1279..255
	localparam int PROD_W  = 23;   // d * (d + 5), -6..1629446
	localparam int SCORE_W = 24;   // three channel terms, -18..4888338
	localparam int BEST_W  = 20;   // best score, -18..262144

	localparam logic [IDX_W-1:0]          PAL_LAST      = IDX_W'(PALETTE_ENTRIES - 1);
	localparam logic signed [BEST_W-1:0]  SCORE_BOUND   = BEST_W'(256 * 256 * 4);
	localparam logic signed [DIFF_W-1:0]  LINEAR_WEIGHT = DIFF_W'(5);
	localparam logic signed [QUERY_W-1:0] CHANNEL_MAX   = QUERY_W'(255);

	// Item kinds
	localparam logic KIND_WRITE = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	// Configuration register indexes
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_SEARCH_FIRST = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_SEARCH_LAST  = CFG_IDX_W'(1);

	// Palette word: red in the low byte
	typedef struct packed {
		logic [CHAN_W-1:0] blue;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] red;
	} entry_t;

	typedef logic signed [QUERY_W-1:0] query_chan_t;

	typedef struct packed {
		query_chan_t blue;
		query_chan_t green;
		query_chan_t red;
	} query_t;

	// Scored entry leaving the distance unit
	typedef struct packed {
		logic                      valid;
		logic [IDX_W-1:0]          idx;
		logic signed [SCORE_W-1:0] score;
	} score_t;

	// Running best held by the tracker
	typedef struct packed {
		logic [IDX_W-1:0]         idx;
		logic signed [BEST_W-1:0] score;
		logic                     exact;
	} best_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_RESULT
	} scan_state_t;

endpackage

FILE: sv/ncs_palette_ram.sv
// Palette memory: one write port, one registered read port.
module ncs_palette_ram (
	input  logic                         clk,
	input  logic                         wr_en,
	input  logic [ncs_pkg::PAL_AW-1:0]   wr_addr,
	input  ncs_pkg::entry_t              wr_data,
	input  logic                         rd_en,
	input  logic [ncs_pkg::PAL_AW-1:0]   rd_addr,
	output ncs_pkg::entry_t              rd_data
);
	import ncs_pkg::*;

	entry_t mem_q [PALETTE_ENTRIES];
	entry_t rd_data_q;

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Read port, data registered
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

FILE: sv/ncs_score_unit.sv
// Distance unit: scores one palette entry per cycle over three pipeline stages.
module ncs_score_unit (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	input  logic [ncs_pkg::IDX_W-1:0] in_idx,
	input  ncs_pkg::entry_t           entry,
	input  ncs_pkg::query_t           query,
	output ncs_pkg::score_t           score,
	output logic                      busy
);
	import ncs_pkg::*;

	logic signed [QUERY_W-1:0]  q_ch     [3];
	logic [CHAN_W-1:0]          p_ch     [3];
	logic signed [DIFF_W-1:0]   diff     [3];
	logic signed [2*DIFF_W-1:0] prod_full[3];
	logic signed [SCORE_W-1:0]  sum;

	logic                       valid_s2, valid_s3, valid_s4;
	logic [IDX_W-1:0]           idx_s2, idx_s3, idx_s4;
	logic signed [DIFF_W-1:0]   d_s2     [3];
	logic signed [DIFF_W-1:0]   dp5_s2   [3];
	logic signed [PROD_W-1:0]   prod_s3  [3];
	logic signed [SCORE_W-1:0]  score_s4;

	// Channel differences
	always_comb begin
		q_ch[0] = query.red;
		q_ch[1] = query.green;
		q_ch[2] = query.blue;
		p_ch[0] = entry.red;
		p_ch[1] = entry.green;
		p_ch[2] = entry.blue;
		for (int i = 0; i < 3; i++) begin
			diff[i] = DIFF_W'(q_ch[i]) - $signed({{(DIFF_W-CHAN_W){1'b0}}, p_ch[i]});
		end
	end

	// d * (d + 5) per channel
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			prod_full[i] = d_s2[i] * dp5_s2[i];
		end
	end

	// Sum of the three channel terms
	assign sum = SCORE_W'(prod_s3[0]) + SCORE_W'(prod_s3[1]) + SCORE_W'(prod_s3[2]);

	// Stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s2 <= in_valid;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	// Stage payloads
	always_ff @(posedge clk) begin
		idx_s2 <= in_idx;
		idx_s3 <= idx_s2;
		idx_s4 <= idx_s3;
		for (int i = 0; i < 3; i++) begin
			d_s2[i]    <= diff[i];
			dp5_s2[i]  <= diff[i] + LINEAR_WEIGHT;
			prod_s3[i] <= prod_full[i][PROD_W-1:0];
		end
		score_s4 <= sum;
	end

	assign score.valid = valid_s4;
	assign score.idx   = idx_s4;
	assign score.score = score_s4;
	assign busy        = valid_s2 | valid_s3 | valid_s4;

endmodule

FILE: sv/ncs_best_track.sv
// Best-score tracker: keeps the first strictly smaller score, latches on an exact hit.
module ncs_best_track (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            clear,
	input  ncs_pkg::score_t score,
	output ncs_pkg::best_t  best
);
	import ncs_pkg::*;

	logic [IDX_W-1:0]         idx_q;
	logic signed [BEST_W-1:0] score_q;
	logic                     exact_q;
	logic                     better;

	// Strictly smaller wins; nothing counts once an exact hit is held
	assign better = score.valid && !exact_q && (score.score < SCORE_W'(score_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			score_q <= SCORE_BOUND;
			exact_q <= 1'b0;
		end else if (clear) begin
			idx_q   <= '0;
			score_q <= SCORE_BOUND;
			exact_q <= 1'b0;
		end else if (better) begin
			idx_q   <= score.idx;
			score_q <= score.score[BEST_W-1:0];
			exact_q <= (score.score == '0);
		end
	end

	assign best.idx   = idx_q;
	assign best.score = score_q;
	assign best.exact = exact_q;

endmodule

FILE: sv/nearest_palette_color_search.sv
// Nearest palette colour search: palette store, scan sequencer and result register.
//
// A palette-write transaction gives no result. A query saturates each channel above 255,
// then scans palette entries search_first..search_last (search_last clipped to the
// palette) one entry per cycle through a single memory read port and a four-deep scoring
// pipeline (read, difference, multiply, sum), keeping the first entry with a strictly
// smaller score than the best so far, starting from 262144. A zero score ends the scan
// early. An exact hit stops issuing as soon as the tracker sees it, up to four entries
// after the hit. The result state waits while the previous result is still stalled. The
// next transaction is taken the cycle after the result is loaded. No new transaction is
// taken while a query is in progress, but the next one is taken while the previous
// result still waits.
module nearest_palette_color_search (
	input  logic                                clk,
	input  logic                                arst_n,
	// item channel
	input  logic                                item_valid,
	output logic                                item_stall,
	input  logic                                kind,
	input  logic [7:0]                          entry_index,
	input  logic [7:0]                          entry_red,
	input  logic [7:0]                          entry_green,
	input  logic [7:0]                          entry_blue,
	input  logic signed [10:0]                  query_red,
	input  logic signed [10:0]                  query_green,
	input  logic signed [10:0]                  query_blue,
	// result channel
	output logic                                result_valid,
	input  logic                                result_stall,
	output logic [7:0]                          best_index,
	output logic signed [19:0]                  best_score,
	output logic                                exact_match,
	// configuration channel
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [ncs_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [7:0]                          cfg_data
);
	import ncs_pkg::*;

	scan_state_t              state_q, state_d;
	logic [IDX_W-1:0]         first_q, last_cfg_q;
	logic [IDX_W-1:0]         idx_q, last_q;
	logic [IDX_W-1:0]         last_sat;
	query_t                   query_q, query_sat;
	logic                     item_acc, wr_en, query_acc;
	logic                     rd_en, trk_clear, out_load;
	logic                     rd_valid_s1;
	logic [IDX_W-1:0]         rd_idx_s1;
	entry_t                   wr_data, rd_data;
	score_t                   score;
	logic                     score_busy;
	best_t                    best;

	logic                     result_valid_q;
	logic [IDX_W-1:0]         best_index_q;
	logic signed [BEST_W-1:0] best_score_q;
	logic                     exact_q;

	// Item handshake
	assign item_acc  = item_valid && !item_stall;
	assign wr_en     = item_acc && (kind == KIND_WRITE) && (entry_index <= PAL_LAST);
	assign query_acc = item_acc && (kind == KIND_QUERY);
	assign wr_data   = '{blue: entry_blue, green: entry_green, red: entry_red};

	// Channel saturation above the top of range
	always_comb begin
		query_sat.red   = (query_red   > CHANNEL_MAX) ? CHANNEL_MAX : query_red;
		query_sat.green = (query_green > CHANNEL_MAX) ? CHANNEL_MAX : query_green;
		query_sat.blue  = (query_blue  > CHANNEL_MAX) ? CHANNEL_MAX : query_blue;
	end

	assign last_sat = (last_cfg_q > PAL_LAST) ? PAL_LAST : last_cfg_q;

	// Configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q    <= IDX_W'(1);
			last_cfg_q <= IDX_W'(254);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_SEARCH_FIRST: first_q    <= cfg_data;
				CFG_SEARCH_LAST:  last_cfg_q <= cfg_data;
				default:          ;
			endcase
		end
	end

	// Sequencer: state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Sequencer: next state and controls
	always_comb begin
		state_d    = state_q;
		item_stall = 1'b1;
		rd_en      = 1'b0;
		trk_clear  = 1'b0;
		out_load   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				item_stall = 1'b0;
				if (query_acc) begin
					trk_clear = 1'b1;
					state_d   = (first_q > last_sat) ? ST_DRAIN : ST_SCAN;
				end
			end
			ST_SCAN: begin
				rd_en = !best.exact;
				if (best.exact || idx_q == last_q) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!rd_valid_s1 && !score_busy) begin
					state_d = ST_RESULT;
				end
			end
			ST_RESULT: begin
				if (!result_valid_q || !result_stall) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Scan index and held query
	always_ff @(posedge clk) begin
		if (query_acc) begin
			idx_q   <= first_q;
			last_q  <= last_sat;
			query_q <= query_sat;
		end else if (rd_en) begin
			idx_q <= idx_q + IDX_W'(1);
		end
	end

	// Read stage tag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_valid_s1 <= 1'b0;
		end else begin
			rd_valid_s1 <= rd_en;
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= idx_q;
	end

	ncs_palette_ram u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (entry_index[PAL_AW-1:0]),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (idx_q[PAL_AW-1:0]),
		.rd_data (rd_data)
	);

	ncs_score_unit u_score (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (rd_valid_s1),
		.in_idx   (rd_idx_s1),
		.entry    (rd_data),
		.query    (query_q),
		.score    (score),
		.busy     (score_busy)
	);

	ncs_best_track u_track (
		.clk    (clk),
		.arst_n (arst_n),
		.clear  (trk_clear),
		.score  (score),
		.best   (best)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (out_load) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			best_index_q <= best.idx;
			best_score_q <= best.score;
			exact_q      <= best.exact;
		end
	end

	assign result_valid = result_valid_q;
	assign best_index   = best_index_q;
	assign best_score   = best_score_q;
	assign exact_match  = exact_q;

	// A new result only comes from the result state
	a_result_from_seq: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(state_q) == ST_RESULT)
		else $error("result offered outside the result state");

	// An exact hit always reports a zero score
	a_exact_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && exact_match |-> best_score == '0)
		else $error("exact match with non-zero score");

	// The scoring pipeline is empty whenever the block is idle
	a_idle_drained: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> !score.valid && !rd_valid_s1)
		else $error("score in flight while idle");

	// The reported score never exceeds the starting bound
	a_score_bound: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> best_score <= SCORE_BOUND)
		else $error("best score above bound");

endmodule
